// ===== src/dkef_pkg.sv =====
// Shared constants, types and helper functions for the debounced key event FIFO.
`timescale 1ns / 1ps

package dkef_pkg;

    // Storage geometry
    localparam int RING_DEPTH = 128;
    localparam int NUM_KEYS   = 4;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Field widths
    localparam int TICK_W   = 16;
    localparam int CODE_W   = 16;
    localparam int KNUM_W   = 32;
    localparam int MASK_W   = 4;
    localparam int REQ_W    = 2;
    localparam int KIDX_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EDGE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // Read status codes
    localparam logic [STAT_W-1:0] RS_NONE  = 2'd0;
    localparam logic [STAT_W-1:0] RS_HIT   = 2'd1;
    localparam logic [STAT_W-1:0] RS_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYNUMS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTLOW    = 2'd2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;

    // Timer unit commands
    typedef struct packed {
        logic             load;
        logic [KEY_W-1:0] load_idx;
        logic             step;
        logic [KEY_W-1:0] step_idx;
    } tmr_ctl_t;

    // Ring commands
    typedef struct packed {
        logic push;
        logic pop_rd;
        logic pop;
    } ring_ctl_t;

    // Ring status
    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    // Build an event code: key number in the upper byte, logical level in bit 0
    function automatic logic [CODE_W-1:0] key_event_code(
        input logic [2:0]        k,
        input logic [KNUM_W-1:0] key_numbers,
        input logic [MASK_W-1:0] pins,
        input logic [MASK_W-1:0] mask
    );
        logic [KNUM_W-1:0] shifted;
        logic [MASK_W-1:0] lvl_vec;
        shifted = key_numbers >> {k, 3'b000};
        lvl_vec = (pins ^ mask) >> k;
        return {shifted[7:0], 7'd0, lvl_vec[0]};
    endfunction

endpackage

// ===== src/debounced_key_event_fifo.sv =====
// Top level: request sequencer, configuration registers and result register.
`timescale 1ns / 1ps

// Debounced key event FIFO. Each request on the s_ channel yields exactly one
// result on the m_ channel. A tick request passes through S_SCAN and then S_DONE:
// the sequencer walks the keys one per cycle through a single shared countdown
// unit and pushes at most one event into the ring per cycle. A rising-edge or
// unknown request goes straight to S_DONE. A read passes through S_RDREQ and
// S_RDPOP, set by the registered read port of the ring memory, unless the ring is
// empty. The block takes one request at a time and accepts the next as soon as the
// previous result sits in the output register. Configuration writes are always
// accepted and should be issued only while the block is idle; writes to undefined indexes are ignored.
module debounced_key_event_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [dkef_pkg::REQ_W-1:0]      s_req_type,
    input  logic [dkef_pkg::KIDX_W-1:0]     s_key_index,
    input  logic [dkef_pkg::MASK_W-1:0]     s_pin_levels,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dkef_pkg::CODE_W-1:0]     m_key_code,
    output logic [dkef_pkg::STAT_W-1:0]     m_read_status,
    output logic                            m_data_available,
    // Configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dkef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dkef_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RDREQ = 3'd2;
    localparam logic [2:0] S_RDPOP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [dkef_pkg::KEY_W-1:0] scan_k_reg;
    logic [dkef_pkg::KEY_W-1:0] scan_k_next;
    logic [dkef_pkg::MASK_W-1:0] pins_reg;
    logic [dkef_pkg::MASK_W-1:0] pins_next;
    logic [dkef_pkg::CODE_W-1:0] res_code_reg;
    logic [dkef_pkg::CODE_W-1:0] res_code_next;
    logic [dkef_pkg::STAT_W-1:0] res_status_reg;
    logic [dkef_pkg::STAT_W-1:0] res_status_next;

    logic                        m_valid_reg;
    logic [dkef_pkg::CODE_W-1:0] m_code_reg;
    logic [dkef_pkg::STAT_W-1:0] m_status_reg;
    logic                        m_avail_reg;
    logic                        out_load;

    logic [dkef_pkg::TICK_W-1:0] debounce_reg;
    logic [dkef_pkg::KNUM_W-1:0] keynums_reg;
    logic [dkef_pkg::MASK_W-1:0] actlow_reg;

    logic                        s_accept;
    logic                        key_in_range;
    dkef_pkg::tmr_ctl_t          tmr_ctl;
    logic                        tmr_expire;
    dkef_pkg::ring_ctl_t         ring_ctl;
    dkef_pkg::ring_stat_t        ring_stat;
    logic [dkef_pkg::CODE_W-1:0] ring_rd_data;
    logic [dkef_pkg::CODE_W-1:0] push_code;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign key_in_range = (int'(s_key_index) < dkef_pkg::NUM_KEYS);
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Code of the key being scanned, from the pins captured with the tick
    assign push_code = dkef_pkg::key_event_code(3'(scan_k_reg), keynums_reg,
                                                pins_reg, actlow_reg);

    // Sequence one request
    always_comb begin
        state_next      = state_reg;
        scan_k_next     = scan_k_reg;
        pins_next       = pins_reg;
        res_code_next   = res_code_reg;
        res_status_next = res_status_reg;
        tmr_ctl         = '0;
        tmr_ctl.load_idx = dkef_pkg::KEY_W'(s_key_index);
        tmr_ctl.step_idx = scan_k_reg;
        ring_ctl        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    pins_next       = s_pin_levels;
                    res_code_next   = '0;
                    res_status_next = dkef_pkg::RS_NONE;
                    scan_k_next     = '0;
                    case (s_req_type)
                        dkef_pkg::REQ_TICK: state_next = S_SCAN;
                        dkef_pkg::REQ_EDGE: begin
                            tmr_ctl.load = key_in_range;
                            state_next   = S_DONE;
                        end
                        dkef_pkg::REQ_READ: state_next = S_RDREQ;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                tmr_ctl.step  = 1'b1;
                ring_ctl.push = tmr_expire;
                if (scan_k_reg == dkef_pkg::KEY_W'(dkef_pkg::NUM_KEYS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    scan_k_next = scan_k_reg + dkef_pkg::KEY_W'(1);
                end
            end
            S_RDREQ: begin
                if (ring_stat.empty) begin
                    res_status_next = dkef_pkg::RS_EMPTY;
                    state_next      = S_DONE;
                end else begin
                    ring_ctl.pop_rd = 1'b1;
                    state_next      = S_RDPOP;
                end
            end
            S_RDPOP: begin
                ring_ctl.pop    = 1'b1;
                res_code_next   = ring_rd_data;
                res_status_next = dkef_pkg::RS_HIT;
                state_next      = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold sequencer state and per-request payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            scan_k_reg <= '0;
        end else begin
            state_reg  <= state_next;
            scan_k_reg <= scan_k_next;
        end
        pins_reg       <= pins_next;
        res_code_reg   <= res_code_next;
        res_status_reg <= res_status_next;
    end

    // Load the result register; drop valid once the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_code_reg   <= res_code_reg;
            m_status_reg <= res_status_reg;
            m_avail_reg  <= !ring_stat.empty;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_key_code       = m_code_reg;
    assign m_read_status    = m_status_reg;
    assign m_data_available = m_avail_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= dkef_pkg::DEBOUNCE_RESET;
            keynums_reg  <= '0;
            actlow_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dkef_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data[dkef_pkg::TICK_W-1:0];
                dkef_pkg::CFG_KEYNUMS:  keynums_reg  <= cfg_data[dkef_pkg::KNUM_W-1:0];
                dkef_pkg::CFG_ACTLOW:   actlow_reg   <= cfg_data[dkef_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    dkef_timer u_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (tmr_ctl),
        .load_value (debounce_reg),
        .expire     (tmr_expire)
    );

    dkef_ring u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ring_ctl),
        .push_data (push_code),
        .rd_data   (ring_rd_data),
        .stat      (ring_stat)
    );

    // Pushes come only from the key scan
    a_push_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ctl.push |-> (state_reg == S_SCAN))
        else $error("ring push outside key scan");

    // A pop always comes in the cycle after its memory read
    a_pop_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ctl.pop |-> $past(ring_ctl.pop_rd))
        else $error("ring pop without preceding read");

    // Never pop an empty ring
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ctl.pop |-> !ring_stat.empty)
        else $error("ring pop while empty");

    // A read that finds no event reports a zero code
    a_empty_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_status == dkef_pkg::RS_EMPTY)) |-> (m_key_code == '0))
        else $error("empty read with nonzero code");

endmodule

// ===== src/dkef_timer.sv =====
// Per-key debounce countdowns with one shared decrement and expiry compare.
`timescale 1ns / 1ps

module dkef_timer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dkef_pkg::tmr_ctl_t          ctl,
    input  logic [dkef_pkg::TICK_W-1:0] load_value,
    output logic                        expire
);

    logic [dkef_pkg::TICK_W-1:0] countdown_reg [dkef_pkg::NUM_KEYS];
    logic [dkef_pkg::NUM_KEYS-1:0] armed_reg;
    logic [dkef_pkg::TICK_W-1:0] sel_count;
    logic                        sel_armed;
    logic                        sel_low;

    // Shared unit: select one key, compare against one, decrement
    always_comb begin
        sel_count = countdown_reg[ctl.step_idx];
        sel_armed = armed_reg[ctl.step_idx];
        sel_low   = (sel_count <= dkef_pkg::TICK_W'(1));
        expire    = ctl.step && sel_armed && sel_low;
    end

    // Reload on a rising edge, count down on a tick step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
            for (int i = 0; i < dkef_pkg::NUM_KEYS; i++) begin
                countdown_reg[i] <= '0;
            end
        end else if (ctl.load) begin
            countdown_reg[ctl.load_idx] <= load_value;
            armed_reg[ctl.load_idx]     <= 1'b1;
        end else if (ctl.step && sel_armed) begin
            if (sel_low) begin
                countdown_reg[ctl.step_idx] <= '0;
                armed_reg[ctl.step_idx]     <= 1'b0;
            end else begin
                countdown_reg[ctl.step_idx] <= sel_count - dkef_pkg::TICK_W'(1);
            end
        end
    end

endmodule

// ===== src/dkef_ring.sv =====
// Event ring: one-write, one-read memory with wrap-around pointers.
`timescale 1ns / 1ps

module dkef_ring (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dkef_pkg::ring_ctl_t         ctl,
    input  logic [dkef_pkg::CODE_W-1:0] push_data,
    output logic [dkef_pkg::CODE_W-1:0] rd_data,
    output dkef_pkg::ring_stat_t        stat
);

    localparam int PW = dkef_pkg::PTR_W;

    logic [dkef_pkg::CODE_W-1:0] mem [dkef_pkg::RING_DEPTH];
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [dkef_pkg::CODE_W-1:0] rd_data_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(dkef_pkg::RING_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Full leaves one slot open so equal pointers mean empty
    always_comb begin
        stat.empty  = (rd_ptr_reg == wr_ptr_reg);
        stat.full   = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
        wr_ptr_next = (ctl.push && !stat.full) ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Write on push, drop when full; registered read of the oldest entry
    always_ff @(posedge aclk) begin
        if (ctl.push && !stat.full) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (ctl.pop_rd) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
